/* hdl/gb3_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb3_pkg: shared types and constants of the 3x3 gaussian blur
// Pixel and window types, the request carried from the front to the back,
// register indexes and reset values of the frame size registers.
// ----------------------------------------------------------------------------
package gb3_pkg;

    // pixel and sum widths
    localparam int PIX_W        = 8;
    localparam int SUM_W        = 12;
    localparam int KERNEL_SHIFT = 4;

    // configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    // frame size limits and reset values
    localparam int MIN_DIM          = 3;
    localparam int BORDER           = 2;
    localparam int FRAME_WIDTH_RST  = 512;
    localparam int FRAME_HEIGHT_RST = 512;

    // request queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QLVL_W = 3;

    typedef logic [PIX_W-1:0] t_pixel;

    // one window column, top to bottom
    typedef struct packed {
        t_pixel top;
        t_pixel mid;
        t_pixel bot;
    } t_column;

    // one filter request: full window plus frame marks
    typedef struct packed {
        t_column left;
        t_column centre;
        t_column right;
        logic    line_end;
        logic    frame_end;
    } t_request;

endpackage

/* hdl/gb3_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb3_ram: generic simple dual-port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hdl/gb3_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb3_fifo: request queue between front and back
// Short register queue; the fill level goes back to the front for flow
// control.
// ----------------------------------------------------------------------------
module gb3_fifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  gb3_pkg::t_request         i_item,
    output logic [gb3_pkg::QLVL_W-1:0] o_level,
    output logic                      o_valid,
    input  logic                      i_pop,
    output gb3_pkg::t_request         o_item
);

    import gb3_pkg::*;

    t_request            r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QLVL_W-1:0]   r_count;
    logic                w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = i_pop & o_valid;
    assign o_item  = r_mem[r_rd_ptr];
    assign o_level = r_count;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + QLVL_W'(1);
            end else if (!i_push && w_pop) begin
                r_count <= r_count - QLVL_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // the front must never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != QLVL_W'(QDEPTH)))
        else $error("request queue overflow");

endmodule

/* hdl/gb3_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb3_front: pixel intake, line stores and window
// Tracks column and row, reads both line stores at the pixel's column,
// shifts the window in the next cycle and queues a request for every
// interior pixel.
// ----------------------------------------------------------------------------
module gb3_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  gb3_pkg::t_pixel               i_pixel,
    input  logic                          i_cfg_wr_en,
    input  logic [gb3_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gb3_pkg::CFG_W-1:0]     i_cfg_wr_data,
    input  logic [gb3_pkg::QLVL_W-1:0]    i_q_level,
    output logic                          o_q_push,
    output gb3_pkg::t_request             o_q_item
);

    import gb3_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int EWM = $clog2(MAX_WIDTH + 1);
    localparam int EW  = (CFG_W > EWM) ? CFG_W : EWM;
    localparam int RST_WIDTH = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
    localparam logic [CW-1:0]    COL_LAST_RST = CW'(RST_WIDTH - 1);
    localparam logic [CFG_W-1:0] ROW_LAST_RST = CFG_W'(FRAME_HEIGHT_RST - 1);

    // position of the next pixel and last position of the frame
    logic [CW-1:0]    r_col;
    logic [CW-1:0]    r_col_last;
    logic [CFG_W-1:0] r_row;
    logic [CFG_W-1:0] r_row_last;
    logic [CW-1:0]    n_col;
    logic [CFG_W-1:0] n_row;

    // second stage: line store data arrives
    logic             r_f1_valid;
    logic             r_f1_emit;
    logic             r_f1_le;
    logic             r_f1_fe;
    t_pixel           r_f1_px;
    logic [CW-1:0]    r_f1_col;

    // window columns two and one to the left of the newest
    t_column          r_win_left;
    t_column          r_win_centre;
    t_column          w_new_col;

    t_pixel           w_up_rd;
    t_pixel           w_mid_rd;
    logic             w_accept;
    logic             w_col_end;
    logic             w_row_end;
    logic             w_cfg_hit;
    logic [EW-1:0]    w_cfg_ext;
    logic [EW-1:0]    w_width_sat;
    logic [CFG_W-1:0] w_height_sat;
    logic [QLVL_W:0]  w_in_flight;

    // flow control: queue level plus the request still in the second stage
    assign w_in_flight = {1'b0, i_q_level} + (QLVL_W+1)'(r_f1_valid);
    assign o_in_stall  = (w_in_flight >= (QLVL_W+1)'(QDEPTH));
    assign w_accept    = i_in_valid & ~o_in_stall;

    // raster position
    assign w_col_end = (r_col == r_col_last);
    assign w_row_end = (r_row == r_row_last);

    always_comb begin
        if (w_col_end) begin
            n_col = '0;
            n_row = w_row_end ? '0 : r_row + CFG_W'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    // saturate the written frame size
    assign w_cfg_hit = i_cfg_wr_en &&
                       ((i_cfg_index == REG_FRAME_WIDTH) || (i_cfg_index == REG_FRAME_HEIGHT));
    assign w_cfg_ext = EW'(i_cfg_wr_data);

    always_comb begin
        if (i_cfg_wr_data < CFG_W'(MIN_DIM)) begin
            w_width_sat  = EW'(MIN_DIM);
            w_height_sat = CFG_W'(MIN_DIM);
        end else if (w_cfg_ext > EW'(MAX_WIDTH)) begin
            w_width_sat  = EW'(MAX_WIDTH);
            w_height_sat = i_cfg_wr_data;
        end else begin
            w_width_sat  = w_cfg_ext;
            w_height_sat = i_cfg_wr_data;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_col_last <= COL_LAST_RST;
            r_row_last <= ROW_LAST_RST;
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= w_accept;
            if (w_cfg_hit) begin
                r_col <= '0;
                r_row <= '0;
                if (i_cfg_index == REG_FRAME_WIDTH) begin
                    r_col_last <= CW'(w_width_sat - EW'(1));
                end else begin
                    r_row_last <= w_height_sat - CFG_W'(1);
                end
            end else if (w_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // pixel and its classification into the second stage
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f1_px   <= i_pixel;
            r_f1_col  <= r_col;
            r_f1_emit <= (r_row >= CFG_W'(BORDER)) && (r_col >= CW'(BORDER));
            r_f1_le   <= w_col_end;
            r_f1_fe   <= w_col_end && w_row_end;
        end
    end

    // line stores: read at intake, rotate in the next cycle
    gb3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .i_clk     (i_clk),
        .i_wr_en   (r_f1_valid),
        .i_wr_addr (r_f1_col),
        .i_wr_data (w_mid_rd),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_col),
        .o_rd_data (w_up_rd)
    );

    gb3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .i_clk     (i_clk),
        .i_wr_en   (r_f1_valid),
        .i_wr_addr (r_f1_col),
        .i_wr_data (r_f1_px),
        .i_rd_en   (w_accept),
        .i_rd_addr (r_col),
        .o_rd_data (w_mid_rd)
    );

    // window shift
    assign w_new_col = '{top: w_up_rd, mid: w_mid_rd, bot: r_f1_px};

    always_ff @(posedge i_clk) begin
        if (r_f1_valid) begin
            r_win_left   <= r_win_centre;
            r_win_centre <= w_new_col;
        end
    end

    // request to the back for interior pixels
    assign o_q_push = r_f1_valid & r_f1_emit;
    assign o_q_item = '{left:      r_win_left,
                        centre:    r_win_centre,
                        right:     w_new_col,
                        line_end:  r_f1_le,
                        frame_end: r_f1_fe};

    // raster position never runs past the frame
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= r_col_last) && (r_row <= r_row_last))
        else $error("raster position outside frame");

    // a pixel is taken only while the queue can still hold its request
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (i_q_level < QLVL_W'(QDEPTH)))
        else $error("pixel accepted with no queue space");

endmodule

/* hdl/gb3_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb3_back: kernel sum and output register
// Applies the 1-2-1 / 2-4-2 / 1-2-1 kernel to a queued window, divides by
// sixteen and holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module gb3_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  gb3_pkg::t_request i_q_item,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output gb3_pkg::t_pixel   o_filtered_pixel,
    output logic              o_line_end,
    output logic              o_frame_end
);

    import gb3_pkg::*;

    logic             r_out_valid;
    t_pixel           r_pixel;
    logic             r_line_end;
    logic             r_frame_end;
    logic             w_room;
    logic [SUM_W-1:0] w_corner;
    logic [SUM_W-1:0] w_edge;
    logic [SUM_W-1:0] w_sum;

    // output register frees when empty or being taken
    assign w_room  = ~r_out_valid | ~i_out_stall;
    assign o_q_pop = i_q_valid & w_room;

    // kernel: corners x1, edges x2, centre x4
    assign w_corner = SUM_W'(i_q_item.left.top)  + SUM_W'(i_q_item.left.bot)
                    + SUM_W'(i_q_item.right.top) + SUM_W'(i_q_item.right.bot);
    assign w_edge   = SUM_W'(i_q_item.left.mid)  + SUM_W'(i_q_item.right.mid)
                    + SUM_W'(i_q_item.centre.top) + SUM_W'(i_q_item.centre.bot);
    assign w_sum    = w_corner + (w_edge << 1) + (SUM_W'(i_q_item.centre.mid) << 2);

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_room) begin
            r_out_valid <= i_q_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_pixel     <= w_sum[KERNEL_SHIFT +: PIX_W];
            r_line_end  <= i_q_item.line_end;
            r_frame_end <= i_q_item.frame_end;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_filtered_pixel = r_pixel;
    assign o_line_end       = r_line_end;
    assign o_frame_end      = r_frame_end;

    // a request taken from the queue shows up at the output next cycle
    a_pop_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_out_valid)
        else $error("popped request lost");

endmodule

/* hdl/gaussian_blur_3x3_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_top: streaming 3x3 gaussian smoothing
// Takes 8-bit pixels in raster order and gives the 1-2-1 / 2-4-2 / 1-2-1
// smoothed interior of the frame with end-of-line and end-of-frame marks.
// ----------------------------------------------------------------------------
// The block takes one pixel every clock unless stalled and gives at most
// one result per pixel. The rate is set by the two line stores, each with
// one read and one write port: a pixel's column is read in the cycle it is
// taken and written back the cycle after. A four-entry request queue sits
// between intake and the kernel, so a stalled output holds up intake only
// once the queue and the second stage hold four requests. Line stores are
// not cleared after reset; the first two lines of each frame fill them. A
// write to the frame width or height register starts a new frame with the
// next pixel.
module gaussian_blur_3x3_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  gb3_pkg::t_pixel               i_pixel,
    // filtered output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output gb3_pkg::t_pixel               o_filtered_pixel,
    output logic                          o_line_end,
    output logic                          o_frame_end,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [gb3_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gb3_pkg::CFG_W-1:0]     i_cfg_wr_data
);

    import gb3_pkg::*;

    logic              w_push;
    t_request          w_push_item;
    logic [QLVL_W-1:0] w_level;
    logic              w_q_valid;
    logic              w_pop;
    t_request          w_pop_item;

    // intake, line stores and window
    gb3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel       (i_pixel),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_level     (w_level),
        .o_q_push      (w_push),
        .o_q_item      (w_push_item)
    );

    // request queue
    gb3_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_level (w_level),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_item  (w_pop_item)
    );

    // kernel and output register
    gb3_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (w_q_valid),
        .i_q_item         (w_pop_item),
        .o_q_pop          (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_filtered_pixel (o_filtered_pixel),
        .o_line_end       (o_line_end),
        .o_frame_end      (o_frame_end)
    );

endmodule
